/* rtl/tga_pkg.sv */
`timescale 1ns / 1ps

package tga_pkg;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] KIND_PIXEL      = 2'd0;
    localparam logic [1:0] KIND_CMAP_REJ   = 2'd1;
    localparam logic [1:0] KIND_TYPE_REJ   = 2'd2;
    localparam logic [1:0] KIND_DEPTH_REJ  = 2'd3;

    localparam int OUT_TDATA_W = 64;

    // One result as it is held in the output stage.
    typedef struct packed {
        logic [1:0]             kind;
        logic                   last;
        logic [OUT_TDATA_W-1:0] data;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* rtl/tga_out_skid.sv */
`timescale 1ns / 1ps

module tga_out_skid
    import tga_pkg::*;
#(
    parameter int DATA_W = RESULT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;

    // The upstream side stalls only when both entries are occupied.
    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            r_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

/* rtl/tga_truecolor_stream_decoder_top.sv */
`timescale 1ns / 1ps

// TGA true-color stream decoder. The block takes a TGA file one byte per
// request on the slave side, with tuser high on the first byte of each file;
// such a byte always abandons any file in progress. It captures the 18-byte
// header and accepts only uncompressed true-color images (no color map,
// image type 2) of 32 bits per pixel; otherwise it sends one rejection
// request whose tuser names the failed check (1 color map, 2 image type,
// 3 depth) and whose tdata and tlast are zero. For an accepted image the ID
// field and color-map bytes are skipped, and every 4-byte BGRA pixel yields
// one request with tuser 0 carrying its screen coordinate and its red,
// green and blue bytes; alpha is dropped. A column is mirrored to
// width-1-x when descriptor bit 4 is set, and a row to height-1-y unless
// descriptor bit 5 is set; the origin registers are then added. tlast marks
// the last pixel of the image. An image of zero width or height gives no
// request. Bytes outside a file are ignored. Every byte is handled in the
// cycle it is accepted, so the block takes one byte per clock while tready
// is high; a result is registered before it is offered on the master side.
// Results leave through a two-entry output stage; tready is low only while
// both entries are full, which needs a second result to arrive while the
// master side stalls, and it rises again the cycle after the master side
// takes a result. Configuration writes must be made while the block is idle.

module tga_truecolor_stream_decoder_top
    import tga_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration: index 0 origin_left, index 1 origin_top.
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    // Slave side.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,  // [7:0] file_byte
    input  logic                   i_s_axis_tuser,  // [0] image_start
    // Master side.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [17:0] screen_x, [35:18] screen_y, [43:36] red, [51:44] green,
    // [59:52] blue, [63:60] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]             o_m_axis_tuser,  // [1:0] result_kind
    output logic                   o_m_axis_tlast   // final_pixel
);

    localparam logic CFG_ORIGIN_LEFT = 1'b0;
    localparam logic CFG_ORIGIN_TOP  = 1'b1;

    // Header byte offsets.
    localparam logic [4:0] HDR_ID_LEN     = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
    localparam logic [4:0] HDR_CMAP_LEN_L = 5'd5;
    localparam logic [4:0] HDR_CMAP_LEN_H = 5'd6;
    localparam logic [4:0] HDR_CMAP_ENTRY = 5'd7;
    localparam logic [4:0] HDR_WIDTH_L    = 5'd12;
    localparam logic [4:0] HDR_WIDTH_H    = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_L   = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_H   = 5'd15;
    localparam logic [4:0] HDR_DEPTH      = 5'd16;
    localparam logic [4:0] HDR_DESC       = 5'd17;

    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_32           = 8'd32;
    localparam int         DESC_RIGHT_TO_LEFT = 4;
    localparam int         DESC_TOP_TO_BOTTOM = 5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS
    } t_phase;

    // Control state.
    t_phase        r_phase,   n_phase;
    logic [4:0]    r_hdr_cnt, n_hdr_cnt;
    logic [21:0]   r_skip,    n_skip;
    logic [1:0]    r_pix_cnt, n_pix_cnt;
    logic [15:0]   r_col,     n_col;
    logic [15:0]   r_row,     n_row;
    logic [15:0]   r_origin_x;
    logic [15:0]   r_origin_y;

    // Header fields and pixel bytes, valid once written.
    logic [7:0]    r_id_len;
    logic [7:0]    r_cmap_type;
    logic [7:0]    r_img_type;
    logic [15:0]   r_cmap_len;
    logic [20:0]   r_cmap_bytes;
    logic [15:0]   r_width;
    logic [15:0]   r_height;
    logic [7:0]    r_depth;
    logic          r_flip_x;
    logic          r_top_down;
    logic [23:0]   r_pix;

    logic          accept;
    t_phase        v_phase;
    logic [4:0]    v_cnt;
    logic          hdr_we;
    logic          pix_we;
    logic [23:0]   cmap_prod;
    logic [23:0]   cmap_round;
    logic [15:0]   ax;
    logic [15:0]   ay;
    logic [17:0]   screen_x;
    logic [17:0]   screen_y;
    logic          is_last;
    logic          res_valid;
    t_result       res;
    t_result       out_res;
    logic          skid_ready;

    assign accept          = i_s_axis_tvalid && skid_ready;
    assign o_s_axis_tready = skid_ready;

    // A start byte restarts the header in the same cycle.
    assign v_phase = i_s_axis_tuser ? PH_HEADER : r_phase;
    assign v_cnt   = i_s_axis_tuser ? 5'd0 : r_hdr_cnt;

    assign hdr_we = accept && (v_phase == PH_HEADER);
    assign pix_we = accept && (v_phase == PH_PIXELS) && (r_pix_cnt != 2'd3);

    // Color-map byte count, (length * entry bits + 7) / 8, formed as the
    // entry size byte arrives; length bytes are already stored by then.
    assign cmap_prod  = {i_s_axis_tdata[7:0], r_cmap_len[7:0]} == 16'd0 ? 24'd0 :
                        24'(r_cmap_len) * 24'(i_s_axis_tdata);
    assign cmap_round = cmap_prod + 24'd7;

    // Pixel coordinates.
    assign ax = r_flip_x   ? (r_width - 16'd1 - r_col) : r_col;
    assign ay = r_top_down ? r_row : (r_height - 16'd1 - r_row);
    assign screen_x = {{2{r_origin_x[15]}}, r_origin_x} + {2'b00, ax};
    assign screen_y = {{2{r_origin_y[15]}}, r_origin_y} + {2'b00, ay};
    assign is_last  = (r_col == r_width - 16'd1) && (r_row == r_height - 16'd1);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_skip    = r_skip;
        n_pix_cnt = r_pix_cnt;
        n_col     = r_col;
        n_row     = r_row;
        res_valid = 1'b0;
        res       = '0;
        if (accept) begin
            n_phase = v_phase;
            unique case (v_phase)
                PH_HEADER: begin
                    n_hdr_cnt = v_cnt + 5'd1;
                    if (v_cnt == HDR_DESC) begin
                        if (r_cmap_type != 8'd0) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res.kind  = KIND_CMAP_REJ;
                        end else if (r_img_type != IMG_TYPE_TRUECOLOR) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res.kind  = KIND_TYPE_REJ;
                        end else if (r_depth != DEPTH_32) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res.kind  = KIND_DEPTH_REJ;
                        end else if (r_width == 16'd0 || r_height == 16'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_skip    = {14'd0, r_id_len} + {1'b0, r_cmap_bytes};
                            n_pix_cnt = 2'd0;
                            n_col     = 16'd0;
                            n_row     = 16'd0;
                            n_phase   = (n_skip == 22'd0) ? PH_PIXELS : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 22'd1;
                    if (r_skip == 22'd1) begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    n_pix_cnt = r_pix_cnt + 2'd1;
                    if (r_pix_cnt == 2'd3) begin
                        // The alpha byte completes the pixel.
                        res_valid = 1'b1;
                        res.kind  = KIND_PIXEL;
                        res.last  = is_last;
                        res.data  = {4'd0, r_pix[7:0], r_pix[15:8], r_pix[23:16],
                                     screen_y, screen_x};
                        if (is_last) begin
                            n_phase = PH_IDLE;
                        end else if (r_col == r_width - 16'd1) begin
                            n_col = 16'd0;
                            n_row = r_row + 16'd1;
                        end else begin
                            n_col = r_col + 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hdr_cnt  <= 5'd0;
            r_skip     <= 22'd0;
            r_pix_cnt  <= 2'd0;
            r_col      <= 16'd0;
            r_row      <= 16'd0;
            r_origin_x <= 16'd0;
            r_origin_y <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_skip    <= n_skip;
            r_pix_cnt <= n_pix_cnt;
            r_col     <= n_col;
            r_row     <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ORIGIN_LEFT: r_origin_x <= i_cfg_data;
                    CFG_ORIGIN_TOP:  r_origin_y <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Header capture: only the fields that the decoder uses are kept.
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            case (v_cnt)
                HDR_ID_LEN:     r_id_len          <= i_s_axis_tdata;
                HDR_CMAP_TYPE:  r_cmap_type       <= i_s_axis_tdata;
                HDR_IMG_TYPE:   r_img_type        <= i_s_axis_tdata;
                HDR_CMAP_LEN_L: r_cmap_len[7:0]   <= i_s_axis_tdata;
                HDR_CMAP_LEN_H: r_cmap_len[15:8]  <= i_s_axis_tdata;
                HDR_CMAP_ENTRY: r_cmap_bytes      <= cmap_round[23:3];
                HDR_WIDTH_L:    r_width[7:0]      <= i_s_axis_tdata;
                HDR_WIDTH_H:    r_width[15:8]     <= i_s_axis_tdata;
                HDR_HEIGHT_L:   r_height[7:0]     <= i_s_axis_tdata;
                HDR_HEIGHT_H:   r_height[15:8]    <= i_s_axis_tdata;
                HDR_DEPTH:      r_depth           <= i_s_axis_tdata;
                HDR_DESC: begin
                    r_flip_x   <= i_s_axis_tdata[DESC_RIGHT_TO_LEFT];
                    r_top_down <= i_s_axis_tdata[DESC_TOP_TO_BOTTOM];
                end
                default: begin
                end
            endcase
        end
        if (pix_we) begin
            case (r_pix_cnt)
                2'd0:    r_pix[7:0]   <= i_s_axis_tdata;
                2'd1:    r_pix[15:8]  <= i_s_axis_tdata;
                default: r_pix[23:16] <= i_s_axis_tdata;
            endcase
        end
    end

    tga_out_skid #(
        .DATA_W (RESULT_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_ready (skid_ready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = out_res.data;
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

endmodule

/* rtl/tga_checker.sv */
`timescale 1ns / 1ps

module tga_checker
    import tga_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]             o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // Rejections carry no coordinate, color or end mark.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_PIXEL) |->
            (o_m_axis_tdata == '0) && !o_m_axis_tlast)
        else $error("rejection result with nonzero payload");

    // The input side stalls only while a result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Taking a result always frees room for the next byte.
    a_drain_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> o_s_axis_tready)
        else $error("input still stalled after a result was taken");

endmodule

bind tga_truecolor_stream_decoder_top tga_checker u_tga_checker (.*);
